// File: rtl/coeff_compress_pack10_defines.svh
// Assertion macros shared by the coefficient compressor RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef COEFF_COMPRESS_PACK10_DEFINES_SVH
`define COEFF_COMPRESS_PACK10_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define CCP10_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define CCP10_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ccp10_pkg.sv
// Shared constants and types for the 10-bit coefficient compressor and packer.
// No dependencies; every RTL module refers to it by scoped names.
package ccp10_pkg;

    localparam int unsigned MODULUS_Q = 7681;

    localparam int COEF_W  = 16;
    localparam int WORD_W  = 10;
    localparam int BYTE_W  = 8;
    localparam int NUM_W   = 27;
    localparam int RECIP_W = 32;

    localparam logic [COEF_W-1:0]  Q_VAL  = COEF_W'(MODULUS_Q);
    // floor(2^32 / Q): estimate is at most one below the true quotient
    localparam logic [RECIP_W-1:0] RECIP  = RECIP_W'((64'd1 << RECIP_W) / MODULUS_Q);
    localparam logic [NUM_W-1:0]   HALF_Q = NUM_W'(MODULUS_Q / 2);

    localparam logic [1:0] LAST_PHASE = 2'd3;

    typedef struct packed {
        logic       pend_valid;
        logic [1:0] phase;
    } t_pk_status;

endpackage

// File: rtl/ccp10_modq.sv
// Two-stage reduction of a 16-bit coefficient modulo Q by reciprocal multiply.
// Depends on ccp10_pkg.
module ccp10_modq (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [ccp10_pkg::COEF_W-1:0]   i_coef,
    output logic                           o_ready,
    output logic                           o_valid,
    output logic [ccp10_pkg::COEF_W-1:0]   o_rem,
    input  logic                           i_ready
);

    logic                               r_a_valid;
    logic [ccp10_pkg::COEF_W-1:0]       r_a_coef;
    logic [ccp10_pkg::COEF_W-1:0]       r_a_qhat;
    logic                               r_b_valid;
    logic [ccp10_pkg::COEF_W-1:0]       r_b_rem;

    logic [ccp10_pkg::COEF_W+ccp10_pkg::RECIP_W-1:0] w_prod;
    logic [2*ccp10_pkg::COEF_W-1:0]     w_qq;
    logic [ccp10_pkg::COEF_W:0]         w_diff;
    logic [ccp10_pkg::COEF_W-1:0]       w_rem;
    logic                               w_ready_a;
    logic                               w_ready_b;

    assign w_ready_b = !r_b_valid || i_ready;
    assign w_ready_a = !r_a_valid || w_ready_b;
    assign o_ready   = w_ready_a;

    always_comb begin
        w_prod = (ccp10_pkg::COEF_W+ccp10_pkg::RECIP_W)'(i_coef)
               * (ccp10_pkg::COEF_W+ccp10_pkg::RECIP_W)'(ccp10_pkg::RECIP);
        w_qq   = (2*ccp10_pkg::COEF_W)'(r_a_qhat) * (2*ccp10_pkg::COEF_W)'(ccp10_pkg::Q_VAL);
        // estimate may be one short: remainder lies in [0, 2Q)
        w_diff = (ccp10_pkg::COEF_W+1)'(r_a_coef) - w_qq[ccp10_pkg::COEF_W:0];
        if (w_diff >= (ccp10_pkg::COEF_W+1)'(ccp10_pkg::Q_VAL)) begin
            w_rem = ccp10_pkg::COEF_W'(w_diff - (ccp10_pkg::COEF_W+1)'(ccp10_pkg::Q_VAL));
        end else begin
            w_rem = w_diff[ccp10_pkg::COEF_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (w_ready_a) begin
                r_a_valid <= i_valid;
            end
            if (w_ready_b) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_a && i_valid) begin
            r_a_coef <= i_coef;
            r_a_qhat <= w_prod[ccp10_pkg::COEF_W+ccp10_pkg::RECIP_W-1:ccp10_pkg::RECIP_W];
        end
        if (w_ready_b && r_a_valid) begin
            r_b_rem <= w_rem;
        end
    end

    assign o_valid = r_b_valid;
    assign o_rem   = r_b_rem;

endmodule

// File: rtl/ccp10_compress.sv
// Two-stage rounding compression of a remainder to a 10-bit word.
// Depends on ccp10_pkg.
module ccp10_compress (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [ccp10_pkg::COEF_W-1:0]   i_rem,
    output logic                           o_ready,
    output logic                           o_valid,
    output logic [ccp10_pkg::WORD_W-1:0]   o_word,
    input  logic                           i_ready
);

    localparam int PROD_W = ccp10_pkg::NUM_W + ccp10_pkg::RECIP_W;
    localparam int QQ_W   = ccp10_pkg::NUM_W + ccp10_pkg::COEF_W;

    logic                               r_c_valid;
    logic [ccp10_pkg::NUM_W-1:0]        r_c_num;
    logic [ccp10_pkg::NUM_W-1:0]        r_c_qhat;
    logic                               r_d_valid;
    logic [ccp10_pkg::WORD_W-1:0]       r_d_word;

    logic [ccp10_pkg::NUM_W-1:0]        w_num;
    logic [PROD_W-1:0]                  w_prod;
    logic [QQ_W-1:0]                    w_qq;
    logic [ccp10_pkg::NUM_W-1:0]        w_diff;
    logic [ccp10_pkg::WORD_W-1:0]       w_word;
    logic                               w_ready_c;
    logic                               w_ready_d;

    assign w_ready_d = !r_d_valid || i_ready;
    assign w_ready_c = !r_c_valid || w_ready_d;
    assign o_ready   = w_ready_c;

    always_comb begin
        // x * 1024 + floor(Q / 2)
        w_num  = (ccp10_pkg::NUM_W'(i_rem) << ccp10_pkg::WORD_W) + ccp10_pkg::HALF_Q;
        w_prod = PROD_W'(w_num) * PROD_W'(ccp10_pkg::RECIP);
        w_qq   = QQ_W'(r_c_qhat) * QQ_W'(ccp10_pkg::Q_VAL);
        w_diff = r_c_num - w_qq[ccp10_pkg::NUM_W-1:0];
        // bump a short estimate; the 10-bit mask wraps 1024 to 0
        w_word = r_c_qhat[ccp10_pkg::WORD_W-1:0]
               + ccp10_pkg::WORD_W'(w_diff >= ccp10_pkg::NUM_W'(ccp10_pkg::Q_VAL));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (w_ready_c) begin
                r_c_valid <= i_valid;
            end
            if (w_ready_d) begin
                r_d_valid <= r_c_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_c && i_valid) begin
            r_c_num  <= w_num;
            r_c_qhat <= w_prod[PROD_W-1:ccp10_pkg::RECIP_W];
        end
        if (w_ready_d && r_c_valid) begin
            r_d_word <= w_word;
        end
    end

    assign o_valid = r_d_valid;
    assign o_word  = r_d_word;

endmodule

// File: rtl/ccp10_packer.sv
// Bit packer: merges 10-bit words LSB first into bytes, with a one-byte overflow slot.
// Depends on ccp10_pkg.
module ccp10_packer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [ccp10_pkg::WORD_W-1:0]   i_word,
    output logic                           o_ready,
    output logic                           o_valid,
    output logic [ccp10_pkg::BYTE_W-1:0]   o_byte,
    output logic                           o_last,
    input  logic                           i_ready,
    output ccp10_pkg::t_pk_status          o_status
);

    logic [5:0]                     r_held;
    logic [1:0]                     r_phase;
    logic                           r_out_valid;
    logic [ccp10_pkg::BYTE_W-1:0]   r_out_byte;
    logic                           r_out_last;
    logic                           r_pend_valid;
    logic [ccp10_pkg::BYTE_W-1:0]   r_pend_byte;

    logic [2:0]                     w_nheld;
    logic [15:0]                    w_acc;
    logic                           w_full;
    logic                           w_take;
    logic [5:0]                     n_held;
    logic [1:0]                     n_phase;

    assign o_ready = !r_pend_valid && (!r_out_valid || i_ready);
    assign w_take  = i_valid && o_ready;

    always_comb begin
        w_nheld = {r_phase, 1'b0};
        w_acc   = 16'(r_held) | (16'(i_word) << w_nheld);
        w_full  = (r_phase == ccp10_pkg::LAST_PHASE);
        if (w_full) begin
            n_held  = 6'd0;
            n_phase = 2'd0;
        end else begin
            n_held  = w_acc[13:8];
            n_phase = r_phase + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held       <= 6'd0;
            r_phase      <= 2'd0;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (w_take) begin
            r_held       <= n_held;
            r_phase      <= n_phase;
            r_out_valid  <= 1'b1;
            r_pend_valid <= w_full;
        end else if (r_out_valid && i_ready) begin
            // advance the overflow byte, or drop the slot
            r_out_valid  <= r_pend_valid;
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_byte  <= w_acc[7:0];
            r_out_last  <= !w_full;
            r_pend_byte <= w_acc[15:8];
        end else if (r_out_valid && i_ready && r_pend_valid) begin
            r_out_byte  <= r_pend_byte;
            r_out_last  <= 1'b1;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_byte   = r_out_byte;
    assign o_last   = r_out_last;
    assign o_status = '{pend_valid: r_pend_valid, phase: r_phase};

endmodule

// File: rtl/coeff_compress_pack10.sv
// Top level of the 10-bit coefficient compressor and byte packer.
// Depends on ccp10_pkg, ccp10_modq, ccp10_compress, ccp10_packer and the defines header.
//
// Usage:
//   Slave stream: one 16-bit raw coefficient per request on s_axis_tdata.
//   Master stream: packed bytes on m_axis_tdata, LSB-first 10-bit words;
//   tlast marks the final byte produced by one coefficient.
//   Coefficients at phases 0..2 of a group of four give one byte; phase 3 gives two.
//   Path: the first byte of a coefficient passes five registers, the first loaded
//   at the accepting edge: modular reduction 2 stages, rounding compression
//   2 stages, packer 1 stage.
//   Throughput: one coefficient per cycle for phases 0..2 while m_axis_tready is
//   high; the two-byte coefficient holds the packer while its overflow byte is sent,
//   so a steady stream falls below that rate, set by the single output byte port.
//   Stall: when m_axis_tready is low the output byte holds and each pipeline stage
//   fills in turn; s_axis_tready drops only once every stage holds a request.
//   Reset (synchronous, active low): clears all valid flags, the held bits and the
//   group phase; bits of a partial group are discarded.
`include "coeff_compress_pack10_defines.svh"

module coeff_compress_pack10 (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [15:0]  i_s_axis_tdata,   // [15:0] coefficient
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [7:0]   o_m_axis_tdata,   // [7:0] packed_byte
    output logic         o_m_axis_tlast    // last_of_run
);

    logic                               w_rem_valid;
    logic [ccp10_pkg::COEF_W-1:0]       w_rem;
    logic                               w_rem_ready;
    logic                               w_word_valid;
    logic [ccp10_pkg::WORD_W-1:0]       w_word;
    logic                               w_word_ready;
    ccp10_pkg::t_pk_status              w_pk_status;

    ccp10_modq u_modq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_coef  (i_s_axis_tdata),
        .o_ready (o_s_axis_tready),
        .o_valid (w_rem_valid),
        .o_rem   (w_rem),
        .i_ready (w_rem_ready)
    );

    ccp10_compress u_compress (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_rem_valid),
        .i_rem   (w_rem),
        .o_ready (w_rem_ready),
        .o_valid (w_word_valid),
        .o_word  (w_word),
        .i_ready (w_word_ready)
    );

    ccp10_packer u_packer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_word_valid),
        .i_word   (w_word),
        .o_ready  (w_word_ready),
        .o_valid  (o_m_axis_tvalid),
        .o_byte   (o_m_axis_tdata),
        .o_last   (o_m_axis_tlast),
        .i_ready  (i_m_axis_tready),
        .o_status (w_pk_status)
    );

    `CCP10_ASSERT_NOW(a_pend_behind_first, i_clk, i_rst_n, w_pk_status.pend_valid, o_m_axis_tvalid && !o_m_axis_tlast, "overflow byte without a leading first byte")
    `CCP10_ASSERT_NEXT(a_second_byte_follows, i_clk, i_rst_n, o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast, o_m_axis_tvalid && o_m_axis_tlast, "second byte of a full group did not follow")
    `CCP10_ASSERT_NEXT(a_group_closes, i_clk, i_rst_n, w_word_valid && w_word_ready && (w_pk_status.phase == ccp10_pkg::LAST_PHASE), w_pk_status.pend_valid && (w_pk_status.phase == 2'd0), "group of four did not close")

endmodule
